@@ rtl/hsec_pkg.sv @@
// Shared types, constants and bit-mapping functions of the Hamming SEC codec.
// No dependencies; used by hamming_sec_encode_correct.
`default_nettype none

package hsec_pkg;

   // Fixed field widths
   localparam int WORD_W = 64;
   localparam int SYN_W  = 7;
   localparam int CFG_W  = 6;
   localparam int LEN_W  = 7;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [SYN_W-1:0]  syn_type;
   typedef logic [LEN_W-1:0]  len_type;

   // Operation codes
   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_CHECK  = 1'b1
   } op_type;

   // Smallest r with 2^r >= m + r + 1
   function automatic int parity_count(input int m);
      int r;
      r = SYN_W;
      for (int i = SYN_W; i >= 1; i--) begin
         if ((1 << i) >= m + i + 1) begin
            r = i;
         end
      end
      return r;
   endfunction

   // Place data bits at the positions that are not powers of two, low to high
   function automatic word_type scatter_data(input word_type data);
      word_type cw;
      int       k;
      cw = '0;
      k  = 0;
      for (int p = 1; p <= WORD_W; p++) begin
         if ((p & (p - 1)) != 0) begin
            cw[p-1] = data[k];
            k++;
         end
      end
      return cw;
   endfunction

   // Syndrome bit i is the XOR over positions whose 1-based index has bit i set
   function automatic syn_type syndrome_of(input word_type cw);
      syn_type s;
      s = '0;
      for (int i = 0; i < SYN_W; i++) begin
         for (int p = 1; p <= WORD_W; p++) begin
            if (((p >> i) & 1) != 0) begin
               s[i] = s[i] ^ cw[p-1];
            end
         end
      end
      return s;
   endfunction

   // Set the parity bits at the power-of-two positions
   function automatic word_type insert_parity(input word_type cw, input syn_type s);
      word_type res;
      res = cw;
      for (int i = 0; i < SYN_W; i++) begin
         if (s[i]) begin
            res[(1 << i) - 1] = 1'b1;
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ rtl/hamming_sec_encode_correct.sv @@
// Hamming single-error-correcting encoder and checker, three-stage pipeline.
// Depends on hsec_pkg for widths, operation codes and bit-mapping functions.
//
//   channel  ports                                   handshake
//   req      req_op, req_word_in                     start high, busy low
//   rsp      rsp_code_word, rsp_syndrome,            rsp_strobe, one cycle
//            rsp_error_found, rsp_beyond_length
//   csr      csr_data_bits                           csr_valid and csr_ready
//
// One item per cycle; each item passes through the registered stages in order
// (scatter/mask, syndrome tree, parity insert or correction). busy stays low,
// so an item may enter in every cycle.
// Reset is synchronous: it drops all items in flight and sets the data length
// to four bits. Results cannot be held off; the strobe marks each for one cycle.
`default_nettype none

module hamming_sec_encode_correct #(
   parameter int MAX_CODE_BITS = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // item request
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_op,
   input  wire logic [hsec_pkg::WORD_W-1:0]  req_word_in,
   // result
   output logic                              rsp_strobe,
   output logic      [hsec_pkg::WORD_W-1:0]  rsp_code_word,
   output logic      [hsec_pkg::SYN_W-1:0]   rsp_syndrome,
   output logic                              rsp_error_found,
   output logic                              rsp_beyond_length,
   // configuration
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [hsec_pkg::CFG_W-1:0]   csr_data_bits
);

   // Largest data length whose codeword fits in MAX_CODE_BITS
   function automatic int max_data_bits();
      int best;
      best = 1;
      for (int m = 1; m < (1 << hsec_pkg::CFG_W); m++) begin
         if (m + hsec_pkg::parity_count(m) <= MAX_CODE_BITS) begin
            best = m;
         end
      end
      return best;
   endfunction

   localparam int MMAX  = max_data_bits();
   localparam int IDX_W = $clog2(hsec_pkg::WORD_W);

   // Codeword length for a written data length
   function automatic hsec_pkg::len_type code_len(input logic [hsec_pkg::CFG_W-1:0] v);
      int m;
      m = int'(v);
      if (m == 0) begin
         m = 1;
      end
      if (m > MMAX) begin
         m = MMAX;
      end
      return hsec_pkg::LEN_W'(m + hsec_pkg::parity_count(m));
   endfunction

   // Mask of the low n positions
   function automatic hsec_pkg::word_type len_mask(input hsec_pkg::len_type n);
      hsec_pkg::word_type mk;
      mk = '0;
      for (int p = 0; p < hsec_pkg::WORD_W; p++) begin
         if (p < int'(n)) begin
            mk[p] = 1'b1;
         end
      end
      return mk;
   endfunction

   localparam logic [hsec_pkg::CFG_W-1:0] DATA_BITS_RESET = hsec_pkg::CFG_W'(4);

   // Configuration: codeword length and its mask
   hsec_pkg::len_type  len_ff,  len_in;
   hsec_pkg::word_type mask_ff, mask_in;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_comb begin
      len_in  = code_len(csr_data_bits);
      mask_in = len_mask(len_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= code_len(DATA_BITS_RESET);
         mask_ff <= len_mask(code_len(DATA_BITS_RESET));
      end else if (csr_valid && csr_ready) begin
         len_ff  <= len_in;
         mask_ff <= mask_in;
      end
   end

   // Stage 1: scatter data or take the codeword, mask to n positions
   logic               s1_valid_ff;
   hsec_pkg::op_type   s1_op_ff;
   hsec_pkg::word_type s1_cw_ff, s1_cw_in;

   always_comb begin
      if (hsec_pkg::op_type'(req_op) == hsec_pkg::OP_ENCODE) begin
         s1_cw_in = hsec_pkg::scatter_data(req_word_in) & mask_ff;
      end else begin
         s1_cw_in = req_word_in & mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_op_ff <= hsec_pkg::op_type'(req_op);
      s1_cw_ff <= s1_cw_in;
   end

   // Stage 2: syndrome XOR trees
   logic               s2_valid_ff;
   hsec_pkg::op_type   s2_op_ff;
   hsec_pkg::word_type s2_cw_ff;
   hsec_pkg::syn_type  s2_syn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_op_ff  <= s1_op_ff;
      s2_cw_ff  <= s1_cw_ff;
      s2_syn_ff <= hsec_pkg::syndrome_of(s1_cw_ff);
   end

   // Stage 3: insert parity, or flag and correct one bit
   logic                         rsp_strobe_ff;
   hsec_pkg::word_type           rsp_cw_ff,     rsp_cw_in;
   hsec_pkg::syn_type            rsp_syn_ff,    rsp_syn_in;
   logic                         rsp_err_ff,    rsp_err_in;
   logic                         rsp_beyond_ff, rsp_beyond_in;
   logic [IDX_W-1:0]             flip_idx;

   always_comb begin
      flip_idx = IDX_W'(s2_syn_ff - hsec_pkg::SYN_W'(1));
      unique case (s2_op_ff)
         hsec_pkg::OP_ENCODE: begin
            rsp_cw_in     = hsec_pkg::insert_parity(s2_cw_ff, s2_syn_ff);
            rsp_syn_in    = '0;
            rsp_err_in    = 1'b0;
            rsp_beyond_in = 1'b0;
         end
         hsec_pkg::OP_CHECK: begin
            rsp_syn_in    = s2_syn_ff;
            rsp_err_in    = (s2_syn_ff != '0);
            rsp_beyond_in = rsp_err_in && (s2_syn_ff > len_ff);
            rsp_cw_in     = s2_cw_ff;
            if (rsp_err_in && !rsp_beyond_in) begin
               rsp_cw_in[flip_idx] = ~s2_cw_ff[flip_idx];
            end
         end
         default: begin
            rsp_cw_in     = s2_cw_ff;
            rsp_syn_in    = '0;
            rsp_err_in    = 1'b0;
            rsp_beyond_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s2_valid_ff;
      end
      rsp_cw_ff     <= rsp_cw_in;
      rsp_syn_ff    <= rsp_syn_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_beyond_ff <= rsp_beyond_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_code_word     = rsp_cw_ff;
   assign rsp_syndrome      = rsp_syn_ff;
   assign rsp_error_found   = rsp_err_ff;
   assign rsp_beyond_length = rsp_beyond_ff;

endmodule

`default_nettype wire
